// ===== rtl/mexp_pkg.sv =====
// Package: shared constants of the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

    // Width of every operand and result field on the channels.
    localparam int FIELD_W = 32;

endpackage

// ===== rtl/mexp_if.sv =====
// Interfaces: operand channel and result channel of the modular exponentiation block.
`timescale 1ns / 1ps

interface mexp_in_if
    import mexp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] base_value;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus;

    modport source (output valid, base_value, exponent, modulus, input ready);
    modport sink   (input valid, base_value, exponent, modulus, output ready);
endinterface

interface mexp_out_if
    import mexp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] power_result;
    logic               modulus_error;

    modport source (output valid, power_result, modulus_error, input ready);
    modport sink   (input valid, power_result, modulus_error, output ready);
endinterface

// ===== rtl/mexp_mulmod.sv =====
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle, MSB first.
`timescale 1ns / 1ps

module mexp_mulmod #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [OPERAND_WIDTH-1:0] i_a,
    input  logic [OPERAND_WIDTH-1:0] i_b,
    input  logic [OPERAND_WIDTH-1:0] i_m,
    output logic                     o_done,
    output logic [OPERAND_WIDTH-1:0] o_product
);

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);
    localparam int SUM_W = W + 2;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_m;

    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_m1;
    logic [SUM_W-1:0] w_m2;
    logic [SUM_W-1:0] w_sub1;
    logic [SUM_W-1:0] w_sub2;
    logic [W-1:0]     n_acc;

    // acc < m and a <= m, so 2*acc + a < 3m: subtract m or 2m at most.
    always_comb begin
        w_sum  = {1'b0, r_acc, 1'b0} + (r_b[W-1] ? SUM_W'(r_a) : '0);
        w_m1   = SUM_W'(r_m);
        w_m2   = {1'b0, r_m, 1'b0};
        w_sub1 = w_sum - w_m1;
        w_sub2 = w_sum - w_m2;
        if (w_sum >= w_m2) begin
            n_acc = w_sub2[W-1:0];
        end else if (w_sum >= w_m1) begin
            n_acc = w_sub1[W-1:0];
        end else begin
            n_acc = w_sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[W-2:0], 1'b0};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ===== rtl/modular_exponentiation.sv =====
// Top level: square-and-multiply modular exponentiation sequencer.
`timescale 1ns / 1ps

// Computes base_value ** exponent mod modulus with one shared bit-serial
// modular multiplier. An item first reduces the base (one product), then does
// one product for each set exponent bit and one squaring for each exponent
// bit below the top set bit, so a 32-bit exponent costs up to 64 products.
// A zero modulus (error flag, result 0) or zero exponent (result 1) skips the
// multiplier and goes straight to the output state. One item is in work at a
// time; a finished result sits in the output register, so the next item is
// taken while it waits. Operands are truncated or zero-extended to
// OPERAND_WIDTH; the result is returned in 32 bits.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mexp_in_if.sink     i_in,
    mexp_out_if.source  o_out
);

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SQR  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [W-1:0]       r_ex, n_ex;
    logic [W-1:0]       r_res, n_res;
    logic [W-1:0]       r_sq, n_sq;
    logic [W-1:0]       r_m, n_m;
    logic               r_err, n_err;
    logic               r_ovalid, n_ovalid;
    logic [FIELD_W-1:0] r_oresult, n_oresult;
    logic               r_oerr, n_oerr;

    logic [W-1:0]       w_base_in;
    logic [W-1:0]       w_ex_in;
    logic [W-1:0]       w_m_in;
    logic               w_start;
    logic [W-1:0]       w_a;
    logic [W-1:0]       w_b;
    logic [W-1:0]       w_mm;
    logic               w_done;
    logic [W-1:0]       w_p;
    logic [W-1:0]       w_cur_res;
    logic [W-1:0]       w_cur_sq;
    logic [W-1:0]       w_ex_sh;

    assign w_base_in = W'(i_in.base_value);
    assign w_ex_in   = W'(i_in.exponent);
    assign w_m_in    = W'(i_in.modulus);

    mexp_mulmod #(
        .OPERAND_WIDTH (W)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_a       (w_a),
        .i_b       (w_b),
        .i_m       (w_mm),
        .o_done    (w_done),
        .o_product (w_p)
    );

    always_comb begin
        w_cur_res = (r_state == S_MUL) ? w_p : r_res;
        w_cur_sq  = (r_state == S_MUL) ? r_sq : w_p;
        w_ex_sh   = r_ex >> 1;
        w_mm      = (r_state == S_IDLE) ? w_m_in : r_m;
    end

    always_comb begin
        n_state   = r_state;
        n_ex      = r_ex;
        n_res     = r_res;
        n_sq      = r_sq;
        n_m       = r_m;
        n_err     = r_err;
        n_ovalid  = r_ovalid & ~o_out.ready;
        n_oresult = r_oresult;
        n_oerr    = r_oerr;
        w_start   = 1'b0;
        w_a       = r_res;
        w_b       = r_sq;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_m   = w_m_in;
                    n_ex  = w_ex_in;
                    n_err = 1'b0;
                    if (w_m_in == '0) begin
                        n_res   = '0;
                        n_err   = 1'b1;
                        n_state = S_OUT;
                    end else if (w_ex_in == '0) begin
                        // exponent zero gives 1, even for a modulus of one
                        n_res   = W'(1);
                        n_state = S_OUT;
                    end else begin
                        n_res   = (w_m_in == W'(1)) ? '0 : W'(1);
                        // base mod m as the product 1 * base
                        w_start = 1'b1;
                        w_a     = W'(1);
                        w_b     = w_base_in;
                        n_state = S_RED;
                    end
                end
            end
            S_RED, S_MUL, S_SQR: begin
                if (w_done) begin
                    n_res = w_cur_res;
                    n_sq  = w_cur_sq;
                    if (r_state != S_MUL && r_ex[0]) begin
                        w_start = 1'b1;
                        w_a     = w_cur_res;
                        w_b     = w_cur_sq;
                        n_state = S_MUL;
                    end else begin
                        n_ex = w_ex_sh;
                        if (w_ex_sh != '0) begin
                            w_start = 1'b1;
                            w_a     = w_cur_sq;
                            w_b     = w_cur_sq;
                            n_state = S_SQR;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_oresult = FIELD_W'(r_res);
                    n_oerr    = r_err;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex      <= n_ex;
        r_res     <= n_res;
        r_sq      <= n_sq;
        r_m       <= n_m;
        r_err     <= n_err;
        r_oresult <= n_oresult;
        r_oerr    <= n_oerr;
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ovalid;
    assign o_out.power_result  = r_oresult;
    assign o_out.modulus_error = r_oerr;

endmodule

// ===== verif/modular_exponentiation_tb.sv =====
// Testbench: random and directed operand sets checked against a square-and-multiply predictor.
`timescale 1ns / 1ps

module modular_exponentiation_tb;
    import mexp_pkg::*;

    // Wait past the longest item before the final verdict.
    localparam int DRAIN_CYCLES  = 2500;
    localparam int PHASE_ITEMS   = 62;

    typedef struct {
        logic [FIELD_W-1:0] base_value;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
    } t_operand;

    typedef struct {
        t_operand           ops;
        logic [FIELD_W-1:0] power_result;
        logic               modulus_error;
    } t_power;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mexp_in_if  in_if ();
    mexp_out_if out_if ();

    modular_exponentiation i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_operand    operand_queue[$];
    t_power      expected_powers[$];
    t_operand    next_ops;
    logic        in_taken = 1'b0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned sets_sent      = 0;
    int unsigned zero_mod_sets  = 0;
    int unsigned zero_exp_sets  = 0;
    int unsigned results_seen   = 0;

    // base ** exponent mod modulus; products of two residues fit in 64 bits
    function automatic t_power compute_power(t_operand ops);
        t_power                r;
        longint unsigned       m;
        longint unsigned       acc;
        longint unsigned       sq;
        logic [FIELD_W-1:0]    ex;
        r.ops           = ops;
        r.modulus_error = 1'b0;
        if (ops.modulus == '0) begin
            r.power_result  = '0;
            r.modulus_error = 1'b1;
        end else if (ops.exponent == '0) begin
            // not reduced, so modulus 1 still yields 1
            r.power_result = 1;
        end else begin
            m   = ops.modulus;
            sq  = ops.base_value % m;
            acc = 1 % m;
            ex  = ops.exponent;
            while (ex != '0) begin
                if (ex[0]) acc = (acc * sq) % m;
                ex = ex >> 1;
                if (ex != '0) sq = (sq * sq) % m;
            end
            r.power_result = acc[FIELD_W-1:0];
        end
        return r;
    endfunction

    function automatic t_operand random_operands();
        t_operand    op;
        int unsigned pick;
        int unsigned w;
        pick = $urandom_range(99);
        if (pick < 5) begin
            op.modulus = '0;
        end else if (pick < 10) begin
            op.modulus = 1;
        end else if (pick < 35) begin
            op.modulus = $urandom;
        end else begin
            w = $urandom_range(2, 32);
            op.modulus = $urandom >> (32 - w);
        end
        // long exponents dominate run time, so most are short
        pick = $urandom_range(99);
        if (pick < 8) begin
            op.exponent = '0;
        end else if (pick < 28) begin
            op.exponent = $urandom;
        end else begin
            w = $urandom_range(1, 10);
            op.exponent = $urandom >> (32 - w);
        end
        pick = $urandom_range(99);
        if (pick < 50 || op.modulus == '0) op.base_value = $urandom;
        else op.base_value = $urandom % op.modulus;
        return op;
    endfunction

    task automatic add_operands(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] e,
                                input logic [FIELD_W-1:0] m);
        t_operand op;
        op.base_value = b;
        op.exponent   = e;
        op.modulus    = m;
        operand_queue.push_back(op);
    endtask

    task automatic report_mismatch(input string what, input t_power exp_r,
                                   input logic [FIELD_W-1:0] got_power, input logic got_err);
        error_count++;
        $display("[%0t] MISMATCH %s: base=%h exp=%h mod=%h expected %h/%b got %h/%b",
                 $realtime, what, exp_r.ops.base_value, exp_r.ops.exponent, exp_r.ops.modulus,
                 exp_r.power_result, exp_r.modulus_error, got_power, got_err);
    endtask

    task automatic wait_all_done();
        while (operand_queue.size() != 0 || in_if.valid || expected_powers.size() != 0)
            @(posedge i_clk);
    endtask

    // driver: new operand set after a transfer or from idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            in_taken = 1'b0;
            if (operand_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_ops = operand_queue.pop_front();
                in_if.base_value <= next_ops.base_value;
                in_if.exponent   <= next_ops.exponent;
                in_if.modulus    <= next_ops.modulus;
                in_if.valid      <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        t_power   exp_r;
        t_operand ops;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            ops.base_value = in_if.base_value;
            ops.exponent   = in_if.exponent;
            ops.modulus    = in_if.modulus;
            expected_powers.push_back(compute_power(ops));
            in_taken = 1'b1;
            sets_sent++;
            if (ops.modulus == '0) zero_mod_sets++;
            if (ops.exponent == '0) zero_exp_sets++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (expected_powers.size() == 0) begin
                exp_r.ops           = '{default: '0};
                exp_r.power_result  = 'x;
                exp_r.modulus_error = 1'bx;
                report_mismatch("unexpected result", exp_r, out_if.power_result,
                                out_if.modulus_error);
            end else begin
                exp_r = expected_powers.pop_front();
                if (out_if.power_result !== exp_r.power_result)
                    report_mismatch("power_result", exp_r, out_if.power_result,
                                    out_if.modulus_error);
                if (out_if.modulus_error !== exp_r.modulus_error)
                    report_mismatch("modulus_error", exp_r, out_if.power_result,
                                    out_if.modulus_error);
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.base_value = '0;
        in_if.exponent   = '0;
        in_if.modulus    = '0;
        out_if.ready     = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero modulus, zero exponent, modulus one, unreduced base, extremes
        add_operands(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        add_operands(32'h0000_0005, 32'h0000_0000, 32'h0000_0007);
        add_operands(32'h0000_0005, 32'h0000_0000, 32'h0000_0001);
        add_operands(32'h0000_007B, 32'h0000_0005, 32'h0000_0001);
        add_operands(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        add_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_operands(32'h0000_0002, 32'h0000_000A, 32'h0000_03E8);
        add_operands(32'h0000_0000, 32'h0000_0005, 32'h0000_000D);
        add_operands(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0061);
        add_operands(32'h0000_0064, 32'h0000_0003, 32'h0000_0007);
        add_operands(32'h0000_0003, 32'h8000_0000, 32'hFFFF_FFFB);
        add_operands(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE);
        add_operands(32'h0000_0007, 32'h0000_0001, 32'h8000_0000);
        add_operands(32'h1234_5678, 32'hFFFF_0000, 32'hFFFF_FFFD);
        add_operands(32'h0000_0002, 32'h0000_001F, 32'h8000_0001);
        add_operands(32'hDEAD_BEEF, 32'h0001_0001, 32'hC000_0001);
        add_operands(32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0002);
        wait_all_done();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                operand_queue.push_back(random_operands());
            // sender holds off until every result of this phase is back
            wait_all_done();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d operand sets (%0d zero modulus, %0d zero exponent),",
                 sets_sent, zero_mod_sets, zero_exp_sets);
        $display("%0d results checked: free flow, idle sender, stalled sink, mixed.",
                 results_seen);
        if (error_count == 0 && expected_powers.size() == 0) begin
            $display("** modular_exponentiation: PASSED **");
        end else begin
            $display("** modular_exponentiation: FAILED **");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d results outstanding", expected_powers.size());
        $display("** modular_exponentiation: FAILED **");
        $finish;
    end

endmodule
